// File: hw/rtl/bqc_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bqc_pkg: shared types and constants of the biquad cascade filter
// Field widths, memory geometry, control codes, the control bundles
// passed between sequencer and datapath, and saturation helpers.
// ----------------------------------------------------------------------------
package bqc_pkg;

  // geometry
  localparam int CHANNELS     = 32;
  localparam int MAX_SECTIONS = 5;
  localparam int SLOTS        = 6;
  localparam int COEF_DEPTH   = SLOTS * MAX_SECTIONS;
  localparam int COEF_AW      = $clog2(COEF_DEPTH);
  localparam int HIST_DEPTH   = CHANNELS * MAX_SECTIONS;
  localparam int HIST_AW      = $clog2(HIST_DEPTH);
  localparam int SWEEP_DEPTH  = (HIST_DEPTH > COEF_DEPTH) ? HIST_DEPTH : COEF_DEPTH;
  localparam int SWEEP_W      = $clog2(SWEEP_DEPTH);
  localparam int SEC_W        = $clog2(MAX_SECTIONS + 1);
  localparam int STEP_W       = 3;

  // field widths
  localparam int OP_W        = 2;
  localparam int CHAN_W      = 5;
  localparam int SAMPLE_W    = 24;
  localparam int CIDX_W      = 5;
  localparam int WORD_W      = 32;
  localparam int CFG_W       = 3;
  localparam int IN_TDATA_W  = 72;
  localparam int OUT_TDATA_W = 32;
  localparam int HIST_W      = 2 * WORD_W;

  // arithmetic
  localparam int PROD_W    = 2 * WORD_W;
  localparam int FRAC_BITS = 30;
  localparam int RP_W      = PROD_W - FRAC_BITS;
  localparam int ACC_W     = RP_W + 2;
  localparam logic signed [PROD_W-1:0] ROUND_HALF = PROD_W'(1) << (FRAC_BITS - 1);

  typedef enum logic [OP_W-1:0] {
    OP_FILTER = 2'd0,
    OP_WRITE  = 2'd1,
    OP_CLEAR  = 2'd2,
    OP_NOP    = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    SLOT_A1   = 3'd0,
    SLOT_A2   = 3'd1,
    SLOT_B0   = 3'd2,
    SLOT_B1   = 3'd3,
    SLOT_B2   = 3'd4,
    SLOT_GAIN = 3'd5
  } slot_t;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_CLEAR,
    ST_SEC,
    ST_FINISH
  } state_t;

  typedef enum logic [2:0] {
    OPND_HIST,
    OPND_W1,
    OPND_W2,
    OPND_W0,
    OPND_Y
  } opnd_t;

  typedef enum logic [2:0] {
    ACC_HOLD,
    ACC_X_MINUS,
    ACC_W0,
    ACC_LOAD,
    ACC_ADD,
    ACC_Y
  } acc_op_t;

  typedef struct packed {
    logic    load_item;
    logic    x_from_prod;
    logic    hist_latch;
    logic    mul_en;
    opnd_t   opnd;
    acc_op_t acc_op;
    logic    out_load;
    logic    finish_from_x;
  } dp_ctrl_t;

  typedef struct packed {
    logic               coef_we;
    logic               coef_wzero;
    logic [COEF_AW-1:0] coef_waddr;
    logic [COEF_AW-1:0] coef_raddr;
    logic               hist_we;
    logic               hist_wzero;
    logic [HIST_AW-1:0] hist_addr;
  } ram_ctrl_t;

  // saturate a wide signed value to one history word
  function automatic logic signed [WORD_W-1:0] sat_word(input logic signed [ACC_W-1:0] v);
    logic [ACC_W-WORD_W:0] hi;
    hi = v[ACC_W-1:WORD_W-1];
    if ((&hi) || (~|hi)) begin
      return v[WORD_W-1:0];
    end else if (v[ACC_W-1]) begin
      return {1'b1, {(WORD_W-1){1'b0}}};
    end else begin
      return {1'b0, {(WORD_W-1){1'b1}}};
    end
  endfunction

  // saturate a wide signed value to one output sample
  function automatic logic signed [SAMPLE_W-1:0] sat_sample(input logic signed [ACC_W-1:0] v);
    logic [ACC_W-SAMPLE_W:0] hi;
    hi = v[ACC_W-1:SAMPLE_W-1];
    if ((&hi) || (~|hi)) begin
      return v[SAMPLE_W-1:0];
    end else if (v[ACC_W-1]) begin
      return {1'b1, {(SAMPLE_W-1){1'b0}}};
    end else begin
      return {1'b0, {(SAMPLE_W-1){1'b1}}};
    end
  endfunction

endpackage
`default_nettype wire

// File: hw/rtl/bqc_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bqc_ram: generic single-clock ram
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module bqc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32,
  localparam int AW = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// File: hw/rtl/bqc_datapath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bqc_datapath: shared multiplier and accumulator of the biquad cascade
// One 32x32 multiply per cycle while mul_en is set, rounding, accumulation and saturation,
// section history registers and the output payload register.
// ----------------------------------------------------------------------------
module bqc_datapath (
  input  wire logic                                    clk,
  input  var  bqc_pkg::dp_ctrl_t                       ctl,
  input  wire logic        [bqc_pkg::CHAN_W-1:0]       in_channel,
  input  wire logic signed [bqc_pkg::SAMPLE_W-1:0]     sample_in,
  input  wire logic        [bqc_pkg::WORD_W-1:0]       coef_rdata,
  input  wire logic        [bqc_pkg::HIST_W-1:0]       hist_rdata,
  output logic             [bqc_pkg::HIST_W-1:0]       hist_wdata,
  output logic             [bqc_pkg::CHAN_W-1:0]       out_channel,
  output logic signed      [bqc_pkg::SAMPLE_W-1:0]     sample_out
);

  logic signed [bqc_pkg::WORD_W-1:0] x, w1, w2, w0, y, opnd, coef_s;
  logic        [bqc_pkg::CHAN_W-1:0] chan;
  logic signed [bqc_pkg::PROD_W-1:0] prod, mul_full, rnd;
  logic signed [bqc_pkg::RP_W-1:0]   rp;
  logic signed [bqc_pkg::ACC_W-1:0]  acc, rp_ext, x_ext, acc_sum, acc_diff, fin_src;

  assign coef_s   = $signed(coef_rdata);
  assign mul_full = coef_s * opnd;

  // round half up, then floor shift
  assign rnd    = prod + bqc_pkg::ROUND_HALF;
  assign rp     = rnd[bqc_pkg::PROD_W-1:bqc_pkg::FRAC_BITS];
  assign rp_ext = {{(bqc_pkg::ACC_W-bqc_pkg::RP_W){rp[bqc_pkg::RP_W-1]}}, rp};
  assign x_ext  = {{(bqc_pkg::ACC_W-bqc_pkg::WORD_W){x[bqc_pkg::WORD_W-1]}}, x};

  assign acc_diff = acc - rp_ext;
  assign acc_sum  = acc + rp_ext;
  assign fin_src  = ctl.finish_from_x ? x_ext : rp_ext;

  // shifted history: new w1 is w0, new w2 is old w1
  assign hist_wdata = {w1, w0};

  always_comb begin
    case (ctl.opnd)
      bqc_pkg::OPND_HIST: opnd = $signed(hist_rdata[bqc_pkg::WORD_W-1:0]);
      bqc_pkg::OPND_W1:   opnd = w1;
      bqc_pkg::OPND_W2:   opnd = w2;
      bqc_pkg::OPND_W0:   opnd = w0;
      bqc_pkg::OPND_Y:    opnd = y;
      default:            opnd = w1;
    endcase
  end

  always_ff @(posedge clk) begin
    if (ctl.load_item) begin
      x    <= {{(bqc_pkg::WORD_W-bqc_pkg::SAMPLE_W){sample_in[bqc_pkg::SAMPLE_W-1]}},
               sample_in};
      chan <= in_channel;
    end else if (ctl.x_from_prod) begin
      x <= bqc_pkg::sat_word(rp_ext);
    end

    if (ctl.hist_latch) begin
      w1 <= $signed(hist_rdata[bqc_pkg::WORD_W-1:0]);
      w2 <= $signed(hist_rdata[bqc_pkg::HIST_W-1:bqc_pkg::WORD_W]);
    end

    if (ctl.mul_en) begin
      prod <= mul_full;
    end

    case (ctl.acc_op)
      bqc_pkg::ACC_X_MINUS: acc <= x_ext - rp_ext;
      bqc_pkg::ACC_W0:      w0  <= bqc_pkg::sat_word(acc_diff);
      bqc_pkg::ACC_LOAD:    acc <= rp_ext;
      bqc_pkg::ACC_ADD:     acc <= acc_sum;
      bqc_pkg::ACC_Y:       y   <= bqc_pkg::sat_word(acc_sum);
      default: ;
    endcase

    if (ctl.out_load) begin
      sample_out  <= bqc_pkg::sat_sample(fin_src);
      out_channel <= chan;
    end
  end

endmodule
`default_nettype wire

// File: hw/rtl/bqc_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bqc_ctrl: sequencer of the biquad cascade
// Handshakes, section register, clearing sweeps, per-section step
// schedule and the memory addresses.
// ----------------------------------------------------------------------------
module bqc_ctrl (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         cfg_wr_en,
  input  wire logic [bqc_pkg::CFG_W-1:0]    cfg_wr_data,
  input  wire logic                         in_valid,
  output logic                              in_ready,
  input  wire logic [bqc_pkg::OP_W-1:0]     in_op,
  input  wire logic [bqc_pkg::CHAN_W-1:0]   in_channel,
  input  wire logic [bqc_pkg::CIDX_W-1:0]   in_coef_index,
  output logic                              out_valid,
  input  wire logic                         out_ready,
  output bqc_pkg::dp_ctrl_t                 ctl,
  output bqc_pkg::ram_ctrl_t                ram
);

  localparam logic [bqc_pkg::STEP_W-1:0] S_FETCH = 3'd0;
  localparam logic [bqc_pkg::STEP_W-1:0] S_LATCH = 3'd1;
  localparam logic [bqc_pkg::STEP_W-1:0] S_FB    = 3'd2;
  localparam logic [bqc_pkg::STEP_W-1:0] S_W0    = 3'd3;
  localparam logic [bqc_pkg::STEP_W-1:0] S_FF0   = 3'd4;
  localparam logic [bqc_pkg::STEP_W-1:0] S_FF1   = 3'd5;
  localparam logic [bqc_pkg::STEP_W-1:0] S_Y     = 3'd6;
  localparam logic [bqc_pkg::STEP_W-1:0] S_GAIN  = 3'd7;

  bqc_pkg::state_t state, state_next;
  bqc_pkg::op_t    op;
  bqc_pkg::slot_t  slot;

  logic [bqc_pkg::CFG_W-1:0]   sections_cfg;
  logic [bqc_pkg::SWEEP_W-1:0] sweep;
  logic [bqc_pkg::STEP_W-1:0]  step;
  logic [bqc_pkg::SEC_W-1:0]   sec_idx, sec_count, sec_n;
  logic [bqc_pkg::COEF_AW-1:0] coef_base;
  logic [bqc_pkg::HIST_AW-1:0] hist_row, hist_base;
  logic                        accept, sweep_done, sec_last, out_free;

  assign op        = bqc_pkg::op_t'(in_op);
  assign accept    = in_valid && in_ready;
  assign out_free  = !out_valid || out_ready;
  assign sec_last  = (sec_idx == bqc_pkg::SEC_W'(sec_count - 1'b1));
  assign sec_n     = (int'(sections_cfg) > bqc_pkg::MAX_SECTIONS) ?
                     bqc_pkg::SEC_W'(bqc_pkg::MAX_SECTIONS) : bqc_pkg::SEC_W'(sections_cfg);
  assign hist_base = bqc_pkg::HIST_AW'((int'(in_channel) % bqc_pkg::CHANNELS)
                                       * bqc_pkg::MAX_SECTIONS);
  assign sweep_done =
    ((state == bqc_pkg::ST_INIT)  && (sweep == bqc_pkg::SWEEP_W'(bqc_pkg::SWEEP_DEPTH - 1))) ||
    ((state == bqc_pkg::ST_CLEAR) && (sweep == bqc_pkg::SWEEP_W'(bqc_pkg::HIST_DEPTH - 1)));

  // next state
  always_comb begin
    state_next = state;
    unique case (state) inside
      bqc_pkg::ST_INIT, bqc_pkg::ST_CLEAR: begin
        if (sweep_done) state_next = bqc_pkg::ST_IDLE;
      end
      bqc_pkg::ST_IDLE: begin
        if (in_valid) begin
          case (op)
            bqc_pkg::OP_FILTER:
              state_next = (sec_n == '0) ? bqc_pkg::ST_FINISH : bqc_pkg::ST_SEC;
            bqc_pkg::OP_CLEAR: state_next = bqc_pkg::ST_CLEAR;
            default: state_next = bqc_pkg::ST_IDLE;
          endcase
        end
      end
      bqc_pkg::ST_SEC: begin
        if ((step == S_GAIN) && sec_last) state_next = bqc_pkg::ST_FINISH;
      end
      bqc_pkg::ST_FINISH: begin
        if (out_free) state_next = bqc_pkg::ST_IDLE;
      end
      default: state_next = bqc_pkg::ST_INIT;
    endcase
  end

  // outputs
  always_comb begin
    in_ready          = (state == bqc_pkg::ST_IDLE);
    ctl               = '0;
    ctl.opnd          = bqc_pkg::OPND_W1;
    ctl.acc_op        = bqc_pkg::ACC_HOLD;
    ctl.finish_from_x = (sec_count == '0);
    slot              = bqc_pkg::SLOT_A1;
    ram               = '0;
    ram.hist_addr     = hist_row;

    unique case (state)
      bqc_pkg::ST_INIT: begin
        ram.hist_we    = (int'(sweep) < bqc_pkg::HIST_DEPTH);
        ram.hist_wzero = 1'b1;
        ram.hist_addr  = bqc_pkg::HIST_AW'(sweep);
        ram.coef_we    = (int'(sweep) < bqc_pkg::COEF_DEPTH);
        ram.coef_wzero = 1'b1;
        ram.coef_waddr = bqc_pkg::COEF_AW'(sweep);
      end
      bqc_pkg::ST_CLEAR: begin
        ram.hist_we    = (int'(sweep) < bqc_pkg::HIST_DEPTH);
        ram.hist_wzero = 1'b1;
        ram.hist_addr  = bqc_pkg::HIST_AW'(sweep);
      end
      bqc_pkg::ST_IDLE: begin
        ctl.load_item  = accept;
        ram.coef_we    = accept && (op == bqc_pkg::OP_WRITE) &&
                         (int'(in_coef_index) < bqc_pkg::COEF_DEPTH);
        ram.coef_waddr = bqc_pkg::COEF_AW'(in_coef_index);
      end
      bqc_pkg::ST_SEC: begin
        case (step)
          S_FETCH: begin
            slot            = bqc_pkg::SLOT_A1;
            ctl.x_from_prod = (sec_idx != '0);
          end
          S_LATCH: begin
            slot           = bqc_pkg::SLOT_A2;
            ctl.hist_latch = 1'b1;
            ctl.mul_en     = 1'b1;
            ctl.opnd       = bqc_pkg::OPND_HIST;
          end
          S_FB: begin
            slot       = bqc_pkg::SLOT_B1;
            ctl.mul_en = 1'b1;
            ctl.opnd   = bqc_pkg::OPND_W2;
            ctl.acc_op = bqc_pkg::ACC_X_MINUS;
          end
          S_W0: begin
            slot       = bqc_pkg::SLOT_B0;
            ctl.mul_en = 1'b1;
            ctl.opnd   = bqc_pkg::OPND_W1;
            ctl.acc_op = bqc_pkg::ACC_W0;
          end
          S_FF0: begin
            slot        = bqc_pkg::SLOT_B2;
            ctl.mul_en  = 1'b1;
            ctl.opnd    = bqc_pkg::OPND_W0;
            ctl.acc_op  = bqc_pkg::ACC_LOAD;
            ram.hist_we = 1'b1;
          end
          S_FF1: begin
            slot       = bqc_pkg::SLOT_GAIN;
            ctl.mul_en = 1'b1;
            ctl.opnd   = bqc_pkg::OPND_W2;
            ctl.acc_op = bqc_pkg::ACC_ADD;
          end
          S_Y: begin
            slot       = bqc_pkg::SLOT_GAIN;
            ctl.acc_op = bqc_pkg::ACC_Y;
          end
          S_GAIN: begin
            slot       = bqc_pkg::SLOT_GAIN;
            ctl.mul_en = 1'b1;
            ctl.opnd   = bqc_pkg::OPND_Y;
          end
          default: slot = bqc_pkg::SLOT_A1;
        endcase
      end
      bqc_pkg::ST_FINISH: begin
        ctl.out_load = out_free;
      end
      default: ;
    endcase

    ram.coef_raddr = bqc_pkg::COEF_AW'(int'(coef_base) + int'(slot));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= bqc_pkg::ST_INIT;
      sections_cfg <= bqc_pkg::CFG_W'(1);
      sweep        <= '0;
      step         <= '0;
      sec_idx      <= '0;
      sec_count    <= '0;
      coef_base    <= '0;
      hist_row     <= '0;
      out_valid    <= 1'b0;
    end else begin
      state <= state_next;

      if (cfg_wr_en) begin
        sections_cfg <= cfg_wr_data;
      end

      if (((state == bqc_pkg::ST_INIT) || (state == bqc_pkg::ST_CLEAR)) && !sweep_done) begin
        sweep <= bqc_pkg::SWEEP_W'(sweep + 1'b1);
      end else begin
        sweep <= '0;
      end

      if (state == bqc_pkg::ST_SEC) begin
        step <= bqc_pkg::STEP_W'(step + 1'b1);
      end else begin
        step <= '0;
      end

      if (accept && (op == bqc_pkg::OP_FILTER)) begin
        sec_idx   <= '0;
        sec_count <= sec_n;
        coef_base <= '0;
        hist_row  <= hist_base;
      end else if ((state == bqc_pkg::ST_SEC) && (step == S_GAIN)) begin
        sec_idx   <= bqc_pkg::SEC_W'(sec_idx + 1'b1);
        coef_base <= bqc_pkg::COEF_AW'(int'(coef_base) + bqc_pkg::SLOTS);
        hist_row  <= bqc_pkg::HIST_AW'(hist_row + 1'b1);
      end

      if (ctl.out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule
`default_nettype wire

// File: hw/rtl/multichannel_biquad_cascade_filter.sv
`default_nettype none
// ----------------------------------------------------------------------------
// multichannel_biquad_cascade_filter: multichannel cascade of DF-II biquads
// Slave stream carries commands (tuser = operation): filter a sample,
// write a coefficient word, or clear all history. Master stream carries
// the filtered sample and its channel, one transaction per filter command.
// cfg_wr_en/cfg_wr_data set the number of sections in use (reset 1,
// values above the section count of the table are clamped).
// One section is an 8-step pass through the single 32x32 multiplier,
// coefficient ram and history ram, for each of the sections in use.
// The next command is accepted once the result sits in the output
// register; no command is taken while a filter transaction runs.
// Coefficient writes and unused codes are taken without leaving the
// idle state; a clear zeroes all history, one row of w1/w2 per cycle.
// After reset a sweep zeroes history and coefficients;
// s_axis_tready stays low during it.
// A stalled receiver holds the result in the output register; the
// following filter transaction waits in its last step until it drains.
// ----------------------------------------------------------------------------
module multichannel_biquad_cascade_filter (
  input  wire logic                              clk,
  input  wire logic                              rst,
  // section count register
  input  wire logic                              cfg_wr_en,
  input  wire logic [bqc_pkg::CFG_W-1:0]         cfg_wr_data,
  // command stream
  input  wire logic                              s_axis_tvalid,
  output logic                                   s_axis_tready,
  // channel, sample_in, coef_index, coef_value, zero pad
  input  wire logic [bqc_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
  // operation
  input  wire logic [bqc_pkg::OP_W-1:0]          s_axis_tuser,
  // result stream
  output logic                                   m_axis_tvalid,
  input  wire logic                              m_axis_tready,
  // out_channel, sample_out, zero pad
  output logic      [bqc_pkg::OUT_TDATA_W-1:0]   m_axis_tdata
);

  bqc_pkg::dp_ctrl_t  ctl;
  bqc_pkg::ram_ctrl_t ram;

  // unpacked command fields
  logic        [bqc_pkg::CHAN_W-1:0]   in_channel;
  logic signed [bqc_pkg::SAMPLE_W-1:0] in_sample;
  logic        [bqc_pkg::CIDX_W-1:0]   in_coef_index;
  logic        [bqc_pkg::WORD_W-1:0]   in_coef_value;

  logic [bqc_pkg::WORD_W-1:0]   coef_rdata, coef_wdata;
  logic [bqc_pkg::HIST_W-1:0]   hist_rdata, hist_wdata, dp_hist_wdata;
  logic [bqc_pkg::CHAN_W-1:0]   out_channel;
  logic signed [bqc_pkg::SAMPLE_W-1:0] sample_out;

  assign in_channel    = s_axis_tdata[4:0];
  assign in_sample     = $signed(s_axis_tdata[28:5]);
  assign in_coef_index = s_axis_tdata[33:29];
  assign in_coef_value = s_axis_tdata[65:34];

  // sweeps write zeros, normal traffic writes live data
  assign coef_wdata = ram.coef_wzero ? '0 : in_coef_value;
  assign hist_wdata = ram.hist_wzero ? '0 : dp_hist_wdata;

  assign m_axis_tdata = {{(bqc_pkg::OUT_TDATA_W - bqc_pkg::SAMPLE_W - bqc_pkg::CHAN_W){1'b0}},
                         sample_out, out_channel};

  bqc_ctrl u_ctrl (
    .clk           (clk),
    .rst           (rst),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data),
    .in_valid      (s_axis_tvalid),
    .in_ready      (s_axis_tready),
    .in_op         (s_axis_tuser),
    .in_channel    (in_channel),
    .in_coef_index (in_coef_index),
    .out_valid     (m_axis_tvalid),
    .out_ready     (m_axis_tready),
    .ctl           (ctl),
    .ram           (ram)
  );

  // a1, a2, b0, b1, b2, gain per section
  bqc_ram #(
    .WIDTH (bqc_pkg::WORD_W),
    .DEPTH (bqc_pkg::COEF_DEPTH)
  ) u_coef_ram (
    .clk   (clk),
    .we    (ram.coef_we),
    .waddr (ram.coef_waddr),
    .wdata (coef_wdata),
    .raddr (ram.coef_raddr),
    .rdata (coef_rdata)
  );

  // one row per channel and section: w2 in the upper word, w1 in the lower
  bqc_ram #(
    .WIDTH (bqc_pkg::HIST_W),
    .DEPTH (bqc_pkg::HIST_DEPTH)
  ) u_hist_ram (
    .clk   (clk),
    .we    (ram.hist_we),
    .waddr (ram.hist_addr),
    .wdata (hist_wdata),
    .raddr (ram.hist_addr),
    .rdata (hist_rdata)
  );

  bqc_datapath u_datapath (
    .clk         (clk),
    .ctl         (ctl),
    .in_channel  (in_channel),
    .sample_in   (in_sample),
    .coef_rdata  (coef_rdata),
    .hist_rdata  (hist_rdata),
    .hist_wdata  (dp_hist_wdata),
    .out_channel (out_channel),
    .sample_out  (sample_out)
  );

endmodule
`default_nettype wire
